// ===== sv/scb_pkg.sv =====
// shared types and constants for the seven-segment command builder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package scb_pkg;

    // digits on the display and the full segment-run length
    localparam int DIGITS = 4;
    localparam logic [2:0] LEN_FULL = 3'd4;

    // largest number the display can show
    localparam logic [13:0] NUM_MAX = 14'd9999;

    // command bytes and segment bits
    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hC0;
    localparam logic [7:0] CMD_BRIGHT = 8'h80;
    localparam logic [7:0] DP_BIT     = 8'h80;
    localparam logic [7:0] SEG_BLANK  = 8'h00;

    // configuration register indexes
    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_PARTITION  = 1'b1;

    // request operations
    typedef enum logic [2:0] {
        OP_NUMBER       = 3'd0,
        OP_PREFIX       = 3'd1,
        OP_SUFFIX       = 3'd2,
        OP_BLANK_ALL    = 3'd3,
        OP_BLANK_PREFIX = 3'd4,
        OP_BLANK_SUFFIX = 3'd5
    } op_t;

    // positions in the byte sequence of one request
    localparam logic [2:0] STEP_DATA = 3'd0;
    localparam logic [2:0] STEP_ADDR = 3'd1;
    localparam logic [2:0] STEP_SEG0 = 3'd2;

    // one request, fully classified, as handed from front to back
    typedef struct packed {
        logic [DIGITS-1:0][7:0] seg;   // seg[0] is the thousands digit
        logic [2:0]             len;   // segment bytes sent, rightmost ones
        logic [1:0]             pos;   // first digit address
    } desc_t;

    // decimal digit to segment pattern, bits 0..6 are A..G
    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/scb_req_if.sv =====
// request channel: valid/ready handshake with the request fields
// no dependencies
`timescale 1ns / 1ps

interface scb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [13:0] number;
    logic        show_leading_zeros;
    logic [2:0]  digit_count;
    logic [1:0]  start_position;

    modport source (
        output valid, operation, number, show_leading_zeros, digit_count, start_position,
        input  ready
    );
    modport sink (
        input  valid, operation, number, show_leading_zeros, digit_count, start_position,
        output ready
    );
endinterface

// ===== sv/scb_byte_if.sv =====
// bus byte channel: valid/ready handshake with one byte and its frame marks
// no dependencies
`timescale 1ns / 1ps

interface scb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;

    modport source (
        output valid, bus_byte, start_before, stop_after, last,
        input  ready
    );
    modport sink (
        input  valid, bus_byte, start_before, stop_after, last,
        output ready
    );
endinterface

// ===== sv/scb_front.sv =====
// front end: accepts requests, classifies them and splits the number into digits
// depends on scb_pkg and scb_req_if
`timescale 1ns / 1ps

module scb_front
    import scb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] partition,
    scb_req_if.sink    req,
    output desc_t      push_desc,
    output logic       push,
    input  logic       q_ready
);

    typedef struct packed {
        logic       zeros;
        logic       blank;
        logic       dp;
        logic       emit;
        logic [2:0] len;
        logic [1:0] pos;
    } ctl_t;

    // largest multiple of w not above n, as a digit
    function automatic logic [3:0] dec_digit(input logic [13:0] n, input logic [13:0] w);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (n >= 14'(k) * w)
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    logic        s1_valid_reg;
    ctl_t        s1_ctl_reg;
    logic [13:0] s1_n_reg;
    logic        s2_valid_reg;
    ctl_t        s2_ctl_reg;
    logic [3:0]  s2_thou_reg;
    logic [9:0]  s2_rem_reg;
    logic        s3_valid_reg;
    ctl_t        s3_ctl_reg;
    logic [3:0]  s3_thou_reg;
    logic [3:0]  s3_hund_reg;
    logic [6:0]  s3_rem_reg;

    ctl_t        s1_ctl_next;
    logic [13:0] s1_n_next;
    logic [3:0]  s2_thou_next;
    logic [13:0] s2_rem_wide;
    logic [3:0]  s3_hund_next;
    logic [13:0] s3_rem_wide;
    logic [3:0]  d_ten;
    logic [13:0] unit_wide;
    logic [3:0]  d_unit;
    logic        lz0;
    logic        lz1;
    logic        lz2;
    logic        s3_leave;
    logic        s3_free;
    logic        s2_free;
    logic        s1_free;

    // stage flow: a stage takes new data when empty or when it moves on
    assign s3_leave = s3_valid_reg && (!s3_ctl_reg.emit || q_ready);
    assign s3_free  = !s3_valid_reg || s3_leave;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign req.ready = s1_free;

    // classify the request: run length, address, blanking and decimal point
    always_comb
    begin
        s1_n_next         = (req.number > NUM_MAX) ? NUM_MAX : req.number;
        s1_ctl_next.zeros = req.show_leading_zeros;
        s1_ctl_next.blank = 1'b0;
        s1_ctl_next.dp    = 1'b0;
        s1_ctl_next.emit  = 1'b1;
        s1_ctl_next.len   = LEN_FULL;
        s1_ctl_next.pos   = 2'd0;
        case (op_t'(req.operation))
            OP_NUMBER:
            begin
                s1_ctl_next.len = (req.digit_count > LEN_FULL) ? LEN_FULL : req.digit_count;
                s1_ctl_next.pos = req.start_position;
            end
            OP_PREFIX:
            begin
                s1_ctl_next.len = (partition == 3'd0) ? LEN_FULL : partition;
                s1_ctl_next.dp  = (partition != 3'd0);
            end
            OP_SUFFIX:
            begin
                s1_ctl_next.len  = LEN_FULL - partition;
                s1_ctl_next.pos  = partition[1:0];
                s1_ctl_next.emit = (partition != LEN_FULL);
            end
            OP_BLANK_ALL:
            begin
                s1_ctl_next.blank = 1'b1;
            end
            OP_BLANK_PREFIX:
            begin
                s1_ctl_next.blank = 1'b1;
                s1_ctl_next.dp    = 1'b1;
                s1_ctl_next.len   = (partition == 3'd0) ? LEN_FULL : partition;
            end
            OP_BLANK_SUFFIX:
            begin
                s1_ctl_next.blank = 1'b1;
                s1_ctl_next.len   = LEN_FULL - partition;
                s1_ctl_next.pos   = partition[1:0];
            end
            default:
            begin
                s1_ctl_next.emit = 1'b0;
            end
        endcase
    end

    // thousands and hundreds digits, one per stage
    assign s2_thou_next = dec_digit(s1_n_reg, 14'd1000);
    assign s2_rem_wide  = s1_n_reg - 14'(s2_thou_next) * 14'd1000;
    assign s3_hund_next = dec_digit({4'd0, s2_rem_reg}, 14'd100);
    assign s3_rem_wide  = {4'd0, s2_rem_reg} - 14'(s3_hund_next) * 14'd100;

    // tens and units, then segment patterns with leading-zero blanking
    assign d_ten     = dec_digit({7'd0, s3_rem_reg}, 14'd10);
    assign unit_wide = {7'd0, s3_rem_reg} - 14'(d_ten) * 14'd10;
    assign d_unit    = unit_wide[3:0];
    assign lz0       = (s3_thou_reg == 4'd0) && !s3_ctl_reg.zeros;
    assign lz1       = lz0 && (s3_hund_reg == 4'd0);
    assign lz2       = lz1 && (d_ten == 4'd0);

    always_comb
    begin
        push_desc.len = s3_ctl_reg.len;
        push_desc.pos = s3_ctl_reg.pos;
        if (s3_ctl_reg.blank)
        begin
            push_desc.seg[0] = SEG_BLANK;
            push_desc.seg[1] = SEG_BLANK;
            push_desc.seg[2] = SEG_BLANK;
            push_desc.seg[3] = SEG_BLANK;
        end
        else
        begin
            push_desc.seg[0] = lz0 ? SEG_BLANK : seg_of_digit(s3_thou_reg);
            push_desc.seg[1] = lz1 ? SEG_BLANK : seg_of_digit(s3_hund_reg);
            push_desc.seg[2] = lz2 ? SEG_BLANK : seg_of_digit(d_ten);
            push_desc.seg[3] = seg_of_digit(d_unit);
        end
        if (s3_ctl_reg.dp)
        begin
            push_desc.seg[3] = push_desc.seg[3] | DP_BIT;
        end
    end

    // items that produce no bytes are dropped here
    assign push = s3_valid_reg && s3_ctl_reg.emit && q_ready;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_n_reg   <= s1_n_next;
        end
        if (s2_free)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_thou_reg <= s2_thou_next;
            s2_rem_reg  <= s2_rem_wide[9:0];
        end
        if (s3_free)
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_thou_reg <= s2_thou_reg;
            s3_hund_reg <= s3_hund_next;
            s3_rem_reg  <= s3_rem_wide[6:0];
        end
    end

endmodule

// ===== sv/scb_queue.sv =====
// descriptor queue between the front and back ends
// depends on scb_pkg
`timescale 1ns / 1ps

module scb_queue
    import scb_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  q_ready,
    input  logic  pop,
    output desc_t head,
    output logic  head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign q_ready    = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // a lone push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

// ===== sv/scb_back.sv =====
// back end: walks one descriptor into its bus byte sequence, one byte per cycle while the receiver is ready
// depends on scb_pkg and scb_byte_if
`timescale 1ns / 1ps

module scb_back
    import scb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] brightness,
    input  desc_t      head,
    input  logic       head_valid,
    output logic       pop,
    scb_byte_if.source rsp
);

    logic [2:0] step_reg;
    logic       out_valid_reg;
    logic [7:0] bus_byte_reg;
    logic       start_reg;
    logic       stop_reg;
    logic       last_reg;

    logic [2:0] step_next;
    logic [7:0] bus_byte_next;
    logic       start_next;
    logic       stop_next;
    logic       last_next;
    logic       load;
    logic       final_step;
    logic [2:0] seg_idx;

    assign load       = head_valid && (!out_valid_reg || rsp.ready);
    assign final_step = (step_reg == head.len + 3'd2);
    assign seg_idx    = step_reg + 3'd2 - head.len;
    assign pop        = load && final_step;
    assign step_next  = final_step ? STEP_DATA : step_reg + 3'd1;

    // byte and frame marks for the current step
    always_comb
    begin
        last_next = 1'b0;
        if (step_reg == STEP_DATA)
        begin
            bus_byte_next = CMD_DATA;
            start_next    = 1'b1;
            stop_next     = 1'b1;
        end
        else if (step_reg == STEP_ADDR)
        begin
            bus_byte_next = CMD_ADDR | {6'd0, head.pos};
            start_next    = 1'b1;
            stop_next     = (head.len == 3'd0);
        end
        else if (final_step)
        begin
            bus_byte_next = CMD_BRIGHT | {4'd0, brightness};
            start_next    = 1'b1;
            stop_next     = 1'b1;
            last_next     = 1'b1;
        end
        else
        begin
            bus_byte_next = head.seg[seg_idx[1:0]];
            start_next    = 1'b0;
            stop_next     = (step_reg == head.len + 3'd1);
        end
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_DATA;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            step_reg      <= step_next;
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bus_byte_reg <= bus_byte_next;
            start_reg    <= start_next;
            stop_reg     <= stop_next;
            last_reg     <= last_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.bus_byte     = bus_byte_reg;
    assign rsp.start_before = start_reg;
    assign rsp.stop_after   = stop_reg;
    assign rsp.last         = last_reg;

    // the closing byte sits in a frame of its own
    a_last_framed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> start_reg && stop_reg)
        else $error("last byte not framed");

    // the step never runs past the brightness command
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> step_reg <= head.len + 3'd2)
        else $error("step beyond end of sequence");

    // finishing a request restarts at the data command
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> step_reg == STEP_DATA)
        else $error("step not reset after request");

endmodule

// ===== sv/seven_segment_command_builder.sv =====
// The first bus byte of a request passes the front stages, the queue and the output register.
// Throughput: one bus byte per cycle from the back end while the receiver is ready, 3 to 7
// bytes per item (3 + digits sent); set by the byte sequencer.
// Ignored operations and a suffix with a full prefix send no bytes; the front drops them.
// Requests are taken every cycle until the descriptor queue and the front stages are full.
// Reset: brightness 15, partition 0, pipeline and queue empty.
`timescale 1ns / 1ps

module seven_segment_command_builder
    import scb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    scb_req_if.sink    req,
    scb_byte_if.source rsp
);

    logic [3:0] brightness_reg;
    logic [2:0] partition_reg;

    desc_t push_desc;
    desc_t head;
    logic  push;
    logic  q_ready;
    logic  pop;
    logic  head_valid;

    // configuration registers; only the low brightness bits are ever used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 4'hF;
            partition_reg  <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS:
                begin
                    brightness_reg <= cfg_data[3:0];
                end
                CFG_PARTITION:
                begin
                    partition_reg <= (cfg_data[2:0] > LEN_FULL) ? 3'd0 : cfg_data[2:0];
                end
                default:
                begin
                    partition_reg <= partition_reg;
                end
            endcase
        end
    end

    scb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .partition (partition_reg),
        .req       (req),
        .push_desc (push_desc),
        .push      (push),
        .q_ready   (q_ready)
    );

    scb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .q_ready    (q_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    scb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .brightness (brightness_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// ===== dv/tb_top.sv =====
// testbench for the seven-segment command builder: directed and random requests,
// bus bytes checked against an in-bench predictor of the command sequence
// depends on scb_pkg, scb_req_if, scb_byte_if and the builder itself
`timescale 1ns / 1ps

module tb_top;
    import scb_pkg::*;

    // run limits and pressure lengths
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 20;
    localparam int ITEMS_PER_CFG = 38;

    // operation codes the block ignores
    localparam logic [2:0] OP_IGNORED_LO = 3'd6;
    localparam logic [2:0] OP_IGNORED_HI = 3'd7;

    // segment patterns of the decimal digits, index is the digit
    localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // one bus byte with its frame marks
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } bus_frame_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    scb_req_if  req_ch ();
    scb_byte_if byte_ch ();

    // predictor copy of the registers and the bytes still due
    logic [7:0] brightness_cfg;
    logic [2:0] partition_cfg;
    bus_frame_t bus_bytes_due[$];

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;

    seven_segment_command_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (byte_ch)
    );

    always #5 clk = ~clk;

    // split a number into four digit patterns, thousands first
    function automatic logic [3:0][7:0] encode_digits(input logic [13:0] num, input bit zeros,
                                                      input bit dp_units);
        logic [3:0][7:0] seg;
        int value;
        int divisor;
        int d;
        bit leading;
        value = (num > NUM_MAX) ? int'(NUM_MAX) : int'(num);
        divisor = 1000;
        leading = 1'b1;
        for (int k = 0; k < DIGITS; k++)
        begin
            d = value / divisor;
            value = value - d * divisor;
            if (d != 0)
                leading = 1'b0;
            if (d == 0 && leading && !zeros && k != DIGITS - 1)
                seg[k] = SEG_BLANK;
            else
                seg[k] = DIGIT_SEGMENTS[d];
            if (dp_units && k == DIGITS - 1)
                seg[k] = seg[k] | DP_BIT;
            divisor = divisor / 10;
        end
        return seg;
    endfunction

    function automatic void add_due(input logic [7:0] b, input bit st, input bit sp, input bit ls);
        bus_frame_t f;
        f.bus_byte = b;
        f.start_before = st;
        f.stop_after = sp;
        f.last = ls;
        bus_bytes_due.push_back(f);
    endfunction

    // data command, address plus rightmost len segments, brightness command
    function automatic void add_command_frames(input logic [3:0][7:0] seg, input int len,
                                               input int pos);
        int n;
        n = (len > DIGITS) ? DIGITS : len;
        add_due(CMD_DATA, 1'b1, 1'b1, 1'b0);
        add_due(CMD_ADDR | 8'(pos & 3), 1'b1, n == 0, 1'b0);
        for (int i = 0; i < n; i++)
            add_due(seg[DIGITS - n + i], 1'b0, i + 1 == n, 1'b0);
        add_due(CMD_BRIGHT | {4'h0, brightness_cfg[3:0]}, 1'b1, 1'b1, 1'b1);
    endfunction

    // bus bytes caused by one accepted request
    function automatic void predict_bus_bytes(input logic [2:0] op, input logic [13:0] num,
                                              input bit zeros, input logic [2:0] cnt,
                                              input logic [1:0] pos);
        logic [3:0][7:0] seg;
        int part;
        part = int'(partition_cfg);
        seg = '0;
        case (op)
            OP_NUMBER:
                add_command_frames(encode_digits(num, zeros, 1'b0), int'(cnt), int'(pos));
            OP_PREFIX:
                add_command_frames(encode_digits(num, zeros, part != 0),
                                   (part == 0) ? DIGITS : part, 0);
            OP_SUFFIX:
                if (part != DIGITS)
                    add_command_frames(encode_digits(num, zeros, 1'b0), DIGITS - part, part);
            OP_BLANK_ALL:
                add_command_frames(seg, DIGITS, 0);
            OP_BLANK_PREFIX:
            begin
                // decimal point stays lit on the last blank digit
                seg[DIGITS - 1] = DP_BIT;
                add_command_frames(seg, (part == 0) ? DIGITS : part, 0);
            end
            OP_BLANK_SUFFIX:
                add_command_frames(seg, DIGITS - part, part);
            default:
                ;
        endcase
    endfunction

    // send one request; random gap first, valid left high after acceptance
    task automatic send_request(input logic [2:0] op, input logic [13:0] num, input bit zeros,
                                input logic [2:0] cnt, input logic [1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.number <= num;
        req_ch.show_leading_zeros <= zeros;
        req_ch.digit_count <= cnt;
        req_ch.start_position <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_bus_bytes(op, num, zeros, cnt, pos);
    endtask

    // random request, mostly valid operations; counted is low for ignored codes
    task automatic send_random_request(output bit counted);
        logic [2:0]  op;
        logic [13:0] num;
        if ($urandom_range(99) < 4)
            op = $urandom_range(1) ? OP_IGNORED_HI : OP_IGNORED_LO;
        else
            op = 3'($urandom_range(5));
        case ($urandom_range(3))
            0:       num = 14'($urandom);
            1:       num = 14'($urandom_range(99));
            2:       num = 14'($urandom_range(9999));
            default: num = $urandom_range(1) ? NUM_MAX : 14'($urandom_range(16383, 9998));
        endcase
        send_request(op, num, 1'($urandom), 3'($urandom), 2'($urandom));
        counted = (op <= OP_BLANK_SUFFIX);
    endtask

    task automatic send_random_batch(input int count);
        int sent;
        bit counted;
        sent = 0;
        while (sent < count)
        begin
            send_random_request(counted);
            if (counted)
                sent++;
        end
    endtask

    // stop offering, wait for every due byte, then let the pipeline empty
    task automatic wait_for_drain(input int extra);
        req_ch.valid <= 1'b0;
        while (bus_bytes_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_BRIGHTNESS)
            brightness_cfg = data;
        else
            partition_cfg = (data[2:0] > 3'd4) ? 3'd0 : data[2:0];
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [7:0] bright, input logic [7:0] part);
        wait_for_drain(SETTLE_WAIT);
        write_register(CFG_BRIGHTNESS, bright);
        write_register(CFG_PARTITION, part);
    endtask

    // extremes of the fields, every operation and the special cases
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        // reset settings: brightness 15, no partition
        send_request(OP_NUMBER, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_NUMBER, NUM_MAX, 1'b0, 3'd4, 2'd0);
        send_request(OP_NUMBER, 14'h3FFF, 1'b1, 3'd7, 2'd3);
        send_request(OP_NUMBER, 14'd7, 1'b1, 3'd4, 2'd0);
        send_request(OP_NUMBER, 14'd1234, 1'b0, 3'd0, 2'd2);
        send_request(OP_NUMBER, 14'd5, 1'b0, 3'd1, 2'd3);
        send_request(OP_PREFIX, 14'd42, 1'b0, 3'd4, 2'd0);
        send_request(OP_SUFFIX, 14'd305, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_ALL, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_PREFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_SUFFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_IGNORED_LO, 14'd1, 1'b0, 3'd4, 2'd0);
        send_request(OP_IGNORED_HI, 14'd2, 1'b1, 3'd4, 2'd1);
        // full prefix: suffix sends nothing, blank suffix sends no segments
        set_registers(8'h00, 8'h04);
        send_request(OP_PREFIX, 14'd1234, 1'b1, 3'd4, 2'd0);
        send_request(OP_SUFFIX, 14'd99, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_PREFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_SUFFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        // split in the middle
        set_registers(8'h5A, 8'h02);
        send_request(OP_PREFIX, 14'd8, 1'b0, 3'd4, 2'd0);
        send_request(OP_SUFFIX, 14'd10000, 1'b1, 3'd4, 2'd0);
        send_request(OP_BLANK_PREFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        send_request(OP_BLANK_SUFFIX, 14'd0, 1'b0, 3'd4, 2'd0);
        // out-of-range partition falls back to no split
        set_registers(8'hA5, 8'hFD);
        send_request(OP_PREFIX, 14'd1000, 1'b0, 3'd4, 2'd0);
        send_request(OP_SUFFIX, 14'd1, 1'b1, 3'd4, 2'd0);
    endtask

    // random requests under each idling mix, two settings per mix
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 76; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            set_registers(8'($urandom), 8'($urandom));
            send_random_batch(ITEMS_PER_CFG);
            set_registers(8'($urandom), {5'($urandom), 3'($urandom_range(4))});
            send_random_batch(ITEMS_PER_CFG);
        end
    endtask

    // long receiver hold-off while requests keep coming, then a drain and a batch with gaps and stalls
    task automatic test_backpressure();
        set_registers(8'hFF, 8'h01);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        send_random_batch(30);
        wait_for_drain(0);
        send_idle_pct = 26;
        stall_pct = 26;
        send_random_batch(10);
    endtask

    // compare one bus byte with the oldest one due
    task automatic check_bus_byte();
        bus_frame_t want;
        if (bus_bytes_due.size() == 0)
        begin
            $error("bus_byte: none expected, got %02h", byte_ch.bus_byte);
            errors++;
        end
        else
        begin
            want = bus_bytes_due.pop_front();
            if (byte_ch.bus_byte !== want.bus_byte)
            begin
                $error("bus_byte: expected %02h, got %02h", want.bus_byte, byte_ch.bus_byte);
                errors++;
            end
            if (byte_ch.start_before !== want.start_before)
            begin
                $error("start_before: expected %0b, got %0b", want.start_before,
                       byte_ch.start_before);
                errors++;
            end
            if (byte_ch.stop_after !== want.stop_after)
            begin
                $error("stop_after: expected %0b, got %0b", want.stop_after, byte_ch.stop_after);
                errors++;
            end
            if (byte_ch.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, byte_ch.last);
                errors++;
            end
        end
    endtask

    // receiver: checks each accepted byte and drives ready
    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && byte_ch.valid && byte_ch.ready)
                check_bus_byte();
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                byte_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                byte_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("seven_segment_command_builder: mismatch");
        $finish;
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BRIGHTNESS;
        cfg_data = 8'h00;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_NUMBER;
        req_ch.number = '0;
        req_ch.show_leading_zeros = 1'b0;
        req_ch.digit_count = '0;
        req_ch.start_position = '0;
        brightness_cfg = 8'hFF;
        partition_cfg = 3'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();

        wait_for_drain(30);
        if (errors == 0)
            $display("seven_segment_command_builder: match");
        else
            $display("seven_segment_command_builder: mismatch");
        $finish;
    end

endmodule
